// ===== rtl/core/pbmd_pkg.sv =====
// Package for the PID balance motor drive: gain register types, direction codes,
// saturation limits, duty constants and reciprocal multipliers.
// No dependencies.
package pbmd_pkg;

  localparam int unsigned TiltW  = 9;
  localparam int unsigned GainW  = 11;
  localparam int unsigned DriveW = 16;
  localparam int unsigned SumW   = 26;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_GAIN_P = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_I = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_D = 2'd2;

  localparam logic signed [GainW-1:0] GAIN_P_RST = 11'sd10;
  localparam logic signed [GainW-1:0] GAIN_I_RST = 11'sd0;
  localparam logic signed [GainW-1:0] GAIN_D_RST = 11'sd0;

  localparam logic signed [SumW-1:0]   LIMIT_WIDE = 26'sd25500;
  localparam logic signed [DriveW-1:0] LIMIT     = 16'sd25500;

  localparam logic [8:0] DUTY_OFFSET      = 9'd35;
  localparam logic [8:0] DUTY_MAX_WIDE    = 9'd255;
  localparam logic [7:0] DUTY_MAX         = 8'd255;
  localparam logic [7:0] LEFT_BOOST       = 8'd10;
  localparam logic [7:0] LEFT_BOOST_LIMIT = 8'd245;

  // drive + 127*200, then divided by 200
  localparam logic signed [16:0] TEL_OFFSET = 17'sd25400;

  // floor(x/100) = (x * 5243) >> 19, exact for x below 43690
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned SHIFT_100 = 19;
  // floor(x/25) = (x * 5243) >> 17, exact for x below 43690
  localparam logic [12:0] RECIP_25  = 13'd5243;
  localparam int unsigned SHIFT_25  = 17;

  typedef enum logic [1:0] {
    DIR_FWD  = 2'd0,
    DIR_BWD  = 2'd1,
    DIR_STOP = 2'd2
  } dir_e;

  typedef struct packed {
    logic signed [GainW-1:0] p;
    logic signed [GainW-1:0] i;
    logic signed [GainW-1:0] d;
  } gains_t;

  function automatic logic signed [DriveW-1:0] clamp_limit(input logic signed [SumW-1:0] x);
    logic signed [DriveW-1:0] r;
    if (x >= LIMIT_WIDE) begin
      r = LIMIT;
    end else if (x <= -LIMIT_WIDE) begin
      r = -LIMIT;
    end else begin
      r = x[DriveW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pbmd_cfg.sv =====
// Gain registers of the PID balance motor drive, written through a plain write port.
// Depends on pbmd_pkg.
module pbmd_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [pbmd_pkg::CfgIdxW-1:0]        idx_i,
  input  logic [pbmd_pkg::GainW-1:0]          data_i,
  output pbmd_pkg::gains_t                    gains_o
);

  pbmd_pkg::gains_t gains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.p <= pbmd_pkg::GAIN_P_RST;
      gains_q.i <= pbmd_pkg::GAIN_I_RST;
      gains_q.d <= pbmd_pkg::GAIN_D_RST;
    end else if (we_i) begin
      case (idx_i)
        pbmd_pkg::CFG_GAIN_P: gains_q.p <= $signed(data_i);
        pbmd_pkg::CFG_GAIN_I: gains_q.i <= $signed(data_i);
        pbmd_pkg::CFG_GAIN_D: gains_q.d <= $signed(data_i);
        default: ;
      endcase
    end
  end

  assign gains_o = gains_q;

endmodule

// ===== rtl/core/pbmd_pid.sv =====
// PID stage: input register, then P, I and D terms with saturation into the drive register.
// Holds the integral sum and previous error. Depends on pbmd_pkg.
module pbmd_pid (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pbmd_pkg::gains_t                       gains_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [pbmd_pkg::TiltW-1:0]      tilt_i,
  output logic                                   drive_valid_o,
  input  logic                                   drive_ready_i,
  output logic signed [pbmd_pkg::DriveW-1:0]     drive_o
);

  logic                                   in_valid_q;
  logic signed [pbmd_pkg::TiltW-1:0]      tilt_q;
  logic                                   drive_valid_q;
  logic signed [pbmd_pkg::DriveW-1:0]     drive_q, drive_d;
  logic signed [pbmd_pkg::DriveW-1:0]     integ_q, integ_d;
  logic signed [pbmd_pkg::TiltW-1:0]      prev_q;

  logic                                   stage_ready;
  logic                                   advance;

  logic signed [19:0]                     p_prod;
  logic signed [23:0]                     p_term;
  logic signed [19:0]                     i_prod;
  logic signed [20:0]                     i_sum;
  logic signed [9:0]                      err_diff;
  logic signed [20:0]                     d_prod;
  logic signed [pbmd_pkg::SumW-1:0]       drive_sum;

  assign stage_ready = !drive_valid_q || drive_ready_i;
  assign in_ready_o  = !in_valid_q || stage_ready;
  assign advance     = in_valid_q && stage_ready;

  always_comb begin
    i_prod    = 20'(gains_i.i) * 20'(tilt_q);
    i_sum     = 21'(integ_q) + 21'(i_prod);
    integ_d   = pbmd_pkg::clamp_limit(26'(i_sum));
    p_prod    = 20'(gains_i.p) * 20'(tilt_q);
    // times ten as 8x + 2x
    p_term    = (24'(p_prod) <<< 3) + (24'(p_prod) <<< 1);
    err_diff  = 10'(tilt_q) - 10'(prev_q);
    d_prod    = 21'(gains_i.d) * 21'(err_diff);
    drive_sum = 26'(p_term) + 26'(integ_d) + 26'(d_prod);
    drive_d   = pbmd_pkg::clamp_limit(drive_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      drive_valid_q <= 1'b0;
      integ_q       <= '0;
      prev_q        <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (stage_ready) begin
        drive_valid_q <= in_valid_q;
      end
      // state moves once per word, as it leaves the input register
      if (advance) begin
        integ_q <= integ_d;
        prev_q  <= tilt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tilt_q <= tilt_i;
    end
    if (advance) begin
      drive_q <= drive_d;
    end
  end

  assign drive_valid_o = drive_valid_q;
  assign drive_o       = drive_q;

endmodule

// ===== rtl/core/pbmd_out.sv =====
// Output stage: PWM duty, held duty on stop, direction and telemetry into the result register.
// Depends on pbmd_pkg.
module pbmd_out (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                drive_valid_i,
  output logic                                drive_ready_o,
  input  logic signed [pbmd_pkg::DriveW-1:0]  drive_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pbmd_pkg::DriveW-1:0]  drive_o,
  output pbmd_pkg::dir_e                      direction_o,
  output logic [7:0]                          duty_right_o,
  output logic [7:0]                          duty_left_o,
  output logic [7:0]                          telemetry_o
);

  logic                                out_valid_q;
  logic [7:0]                          held_q, held_d;
  logic signed [pbmd_pkg::DriveW-1:0]  drive_q;
  pbmd_pkg::dir_e                      dir_q, dir_d;
  logic [7:0]                          right_q, left_q, left_d;
  logic [7:0]                          tel_q, tel_d;

  logic                                advance;
  logic                                nonzero;
  logic                                neg;
  logic [14:0]                         mag;
  logic [27:0]                         mag_prod;
  logic [8:0]                          duty_sum;
  logic [7:0]                          duty;
  logic signed [16:0]                  tel_sum;
  logic [12:0]                         tel_eighth;
  logic [25:0]                         tel_prod;

  assign drive_ready_o = !out_valid_q || out_ready_i;
  assign advance       = drive_valid_i && drive_ready_o;

  always_comb begin
    nonzero  = (drive_i != '0);
    neg      = drive_i[pbmd_pkg::DriveW-1];
    mag      = neg ? 15'(-drive_i) : 15'(drive_i);
    mag_prod = 28'(mag) * 28'(pbmd_pkg::RECIP_100);
    duty_sum = 9'(mag_prod >> pbmd_pkg::SHIFT_100) + pbmd_pkg::DUTY_OFFSET;
    duty     = (duty_sum >= pbmd_pkg::DUTY_MAX_WIDE) ? pbmd_pkg::DUTY_MAX : duty_sum[7:0];
    held_d   = nonzero ? duty : held_q;
    left_d   = (held_d <= pbmd_pkg::LEFT_BOOST_LIMIT) ? held_d + pbmd_pkg::LEFT_BOOST
                                                      : pbmd_pkg::DUTY_MAX;
    if (!nonzero) begin
      dir_d = pbmd_pkg::DIR_STOP;
    end else if (neg) begin
      dir_d = pbmd_pkg::DIR_BWD;
    end else begin
      dir_d = pbmd_pkg::DIR_FWD;
    end
    // divide by 200 as divide by 8, then by 25
    tel_sum    = 17'(drive_i) + pbmd_pkg::TEL_OFFSET;
    tel_eighth = tel_sum[15:3];
    tel_prod   = 26'(tel_eighth) * 26'(pbmd_pkg::RECIP_25);
    tel_d      = tel_sum[16] ? 8'd0 : 8'(tel_prod >> pbmd_pkg::SHIFT_25);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      if (drive_ready_o) begin
        out_valid_q <= drive_valid_i;
      end
      if (advance) begin
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q <= drive_i;
      dir_q   <= dir_d;
      right_q <= held_d;
      left_q  <= left_d;
      tel_q   <= tel_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drive_o      = drive_q;
  assign direction_o  = dir_q;
  assign duty_right_o = right_q;
  assign duty_left_o  = left_q;
  assign telemetry_o  = tel_q;

endmodule

// ===== rtl/core/pid_balance_motor_drive.sv =====
// Top level of the PID balance motor drive: gain registers, PID stage and output stage.
// Depends on pbmd_pkg, pbmd_cfg, pbmd_pid and pbmd_out.
//
//   channel   direction  word
//   s_axis    in         tdata[8:0] tilt_angle, tdata[15:9] zero
//   m_axis    out        drive_hundredths, direction, duty_right, duty_left, telemetry_byte
//   cfg       in         cfg_idx_i selects gain P, I or D; cfg_data_i holds 11 bits
//
// One word per cycle sustained while m_axis is ready; an accepted word passes the input
// register, the drive register and the result register before its result appears.
// Reset clears the integral sum, previous error, held duty and gains (P to 1.0).
// No clearing pass after reset. Under a stall on m_axis the three registers fill,
// and s_axis_tready drops only when all three hold words.
module pid_balance_motor_drive (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [8:0] tilt_angle
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] drive_hundredths, [17:16] direction, [25:18] duty_right,
  // [33:26] duty_left, [41:34] telemetry_byte
  output logic [47:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [10:0]  cfg_data_i
);

  pbmd_pkg::gains_t                     gains;
  logic                                 drive_valid;
  logic                                 drive_ready;
  logic signed [pbmd_pkg::DriveW-1:0]   drive;
  logic signed [pbmd_pkg::DriveW-1:0]   out_drive;
  pbmd_pkg::dir_e                       out_dir;
  logic [7:0]                           out_right;
  logic [7:0]                           out_left;
  logic [7:0]                           out_tel;

  pbmd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .data_i  (cfg_data_i),
    .gains_o (gains)
  );

  pbmd_pid u_pid (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gains_i       (gains),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .tilt_i        ($signed(s_axis_tdata[8:0])),
    .drive_valid_o (drive_valid),
    .drive_ready_i (drive_ready),
    .drive_o       (drive)
  );

  pbmd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .drive_valid_i (drive_valid),
    .drive_ready_o (drive_ready),
    .drive_i       (drive),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .drive_o       (out_drive),
    .direction_o   (out_dir),
    .duty_right_o  (out_right),
    .duty_left_o   (out_left),
    .telemetry_o   (out_tel)
  );

  assign m_axis_tdata = {6'd0, out_tel, out_left, out_right, out_dir, out_drive};

endmodule

// ===== rtl/core/pbmd_checker.sv =====
// Port-level checks on the PID balance motor drive, attached by bind.
// Depends on pbmd_pkg and pid_balance_motor_drive.
module pbmd_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata
);

  logic signed [15:0] drive;
  logic [1:0]         dir;
  logic [7:0]         right;
  logic [7:0]         left;

  assign drive = $signed(m_axis_tdata[15:0]);
  assign dir   = m_axis_tdata[17:16];
  assign right = m_axis_tdata[25:18];
  assign left  = m_axis_tdata[33:26];

  // stop exactly when drive is zero
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((dir == pbmd_pkg::DIR_STOP) == (drive == 16'sd0)))
    else $error("stop direction disagrees with zero drive");

  a_dir_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (dir == pbmd_pkg::DIR_BWD) |-> drive[15])
    else $error("backward direction with nonnegative drive");

  a_drive_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (drive <= 16'sd25500) && (drive >= -16'sd25500))
    else $error("drive outside saturation limit");

  a_left_boost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((right <= 8'd245) ? (left == right + 8'd10) : (left == 8'd255)))
    else $error("left duty not derived from right duty");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

endmodule

bind pid_balance_motor_drive pbmd_checker u_pbmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/pid_balance_motor_drive_chk.sv =====
// Scoreboard for the PID balance motor drive: tracks gain writes, predicts each result
// word from every accepted tilt word and compares it on m_axis, field by field.
// Depends on pbmd_pkg.
module pid_balance_motor_drive_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [8:0] tilt_angle
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] drive_hundredths, [17:16] direction, [25:18] duty_right,
  // [33:26] duty_left, [41:34] telemetry_byte
  input  logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  output int          errors_o,
  output int          outstanding_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DriveLimit   = 25500;
  localparam int DutyBase     = 35;
  localparam int DutyCeil     = 255;
  localparam int TelemetryMid = 127 * 200;

  typedef struct packed {
    logic signed [pbmd_pkg::DriveW-1:0] drive;
    pbmd_pkg::dir_e                     dir;
    logic [7:0]                         duty_right;
    logic [7:0]                         duty_left;
    logic [7:0]                         telemetry;
  } drive_word_t;

  logic signed [pbmd_pkg::GainW-1:0]  gain_p;
  logic signed [pbmd_pkg::GainW-1:0]  gain_i;
  logic signed [pbmd_pkg::GainW-1:0]  gain_d;
  logic signed [pbmd_pkg::DriveW-1:0] integral_sum;
  logic signed [pbmd_pkg::TiltW-1:0]  prev_error;
  logic [7:0]                         held_duty;

  drive_word_t drive_words_q[$];

  initial begin
    errors_o      = 0;
    outstanding_o = 0;
    results_o     = 0;
  end

  function automatic int saturate_drive(input int x);
    if (x >= DriveLimit) return DriveLimit;
    if (x <= -DriveLimit) return -DriveLimit;
    return x;
  endfunction

  // One control update: advances the integral, previous error and held duty.
  task automatic pid_update(input logic signed [pbmd_pkg::TiltW-1:0] tilt,
                            output drive_word_t w);
    int err;
    int isum;
    int drv;
    int mag;
    int duty;
    int tel;
    err  = int'(tilt);
    isum = saturate_drive(int'(integral_sum) + int'(gain_i) * err);
    drv  = int'(gain_p) * err * 10 + isum + int'(gain_d) * (err - int'(prev_error));
    drv  = saturate_drive(drv);
    integral_sum = isum[pbmd_pkg::DriveW-1:0];
    prev_error   = tilt;
    if (drv != 0) begin
      mag  = (drv > 0) ? drv : -drv;
      duty = mag / 100 + DutyBase;
      if (duty > DutyCeil) duty = DutyCeil;
      held_duty = duty[7:0];
      w.dir = (drv > 0) ? pbmd_pkg::DIR_FWD : pbmd_pkg::DIR_BWD;
    end else begin
      // stop: duty stays where the last moving update left it
      w.dir = pbmd_pkg::DIR_STOP;
    end
    w.duty_right = held_duty;
    w.duty_left  = (held_duty <= pbmd_pkg::LEFT_BOOST_LIMIT) ?
                   held_duty + pbmd_pkg::LEFT_BOOST : pbmd_pkg::DUTY_MAX;
    tel = drv + TelemetryMid;
    if (tel < 0) tel = 0;
    tel = tel / 200;
    w.drive     = drv[pbmd_pkg::DriveW-1:0];
    w.telemetry = tel[7:0];
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drive_word_t want;
    drive_word_t pred;
    if (!rst_ni) begin
      gain_p        = pbmd_pkg::GAIN_P_RST;
      gain_i        = pbmd_pkg::GAIN_I_RST;
      gain_d        = pbmd_pkg::GAIN_D_RST;
      integral_sum  = '0;
      prev_error    = '0;
      held_duty     = '0;
      drive_words_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pbmd_pkg::CFG_GAIN_P: gain_p = cfg_data_i;
          pbmd_pkg::CFG_GAIN_I: gain_i = cfg_data_i;
          pbmd_pkg::CFG_GAIN_D: gain_d = cfg_data_i;
          default: ;
        endcase
      end
      // compare before pushing: a word accepted now cannot have its result yet
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (drive_words_q.size() == 0) begin
          $error("result word with nothing pending: drive %0d",
                 $signed(m_axis_tdata[15:0]));
          errors_o++;
        end else begin
          want = drive_words_q.pop_front();
          check_field("drive_hundredths", int'(want.drive), int'($signed(m_axis_tdata[15:0])));
          check_field("direction", int'(want.dir), int'(m_axis_tdata[17:16]));
          check_field("duty_right", int'(want.duty_right), int'(m_axis_tdata[25:18]));
          check_field("duty_left", int'(want.duty_left), int'(m_axis_tdata[33:26]));
          check_field("telemetry_byte", int'(want.telemetry), int'(m_axis_tdata[41:34]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pid_update($signed(s_axis_tdata[pbmd_pkg::TiltW-1:0]), pred);
        drive_words_q.push_back(pred);
      end
      outstanding_o <= drive_words_q.size();
    end
  end

endmodule

// ===== tb/pid_balance_motor_drive_tb.sv =====
// Top of the PID balance motor drive testbench: clock, reset, gain programming and
// tilt stimulus under several flow-control mixes, watchdog and verdict.
// Depends on pbmd_pkg, pid_balance_motor_drive and pid_balance_motor_drive_chk.
module pid_balance_motor_drive_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CfgUnused     = 2'd3;
  localparam logic [10:0] GainTop       = 11'h3FF;
  localparam logic [10:0] GainBottom    = 11'h400;
  localparam int          PhaseCount    = 9;
  localparam int          PhaseWords    = 120;
  localparam int          HoldCycles    = 80;
  localparam int          WatchdogLimit = 2000;

  typedef enum int { GAINS_SMALL, GAINS_FULL, GAINS_TOP, GAINS_BOTTOM } gain_mix_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [10:0] cfg_data_i    = '0;

  int errors;
  int outstanding;
  int results;
  int idle_pct     = 0;
  int stall_pct    = 0;
  bit hold_req     = 1'b0;
  int words_sent   = 0;
  int gain_sets    = 0;
  int quiet_cycles = 0;
  int tilt_walk    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pid_balance_motor_drive u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  pid_balance_motor_drive_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .results_o     (results)
  );

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no word moved for %0d cycles, %0d predictions pending",
               WatchdogLimit, outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_tilt(input logic [pbmd_pkg::TiltW-1:0] tilt);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, tilt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic program_gains(input logic [10:0] p, input logic [10:0] i,
                               input logic [10:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pbmd_pkg::CFG_GAIN_P;
    cfg_data_i <= p;
    @(posedge clk_i);
    cfg_idx_i  <= pbmd_pkg::CFG_GAIN_I;
    cfg_data_i <= i;
    @(posedge clk_i);
    cfg_idx_i  <= pbmd_pkg::CFG_GAIN_D;
    cfg_data_i <= d;
    @(posedge clk_i);
    // no register behind this index: the write must leave the gains alone
    cfg_idx_i  <= CfgUnused;
    cfg_data_i <= 11'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    gain_sets++;
  endtask

  function automatic logic [10:0] pick_gain(input gain_mix_e mix);
    case (mix)
      GAINS_SMALL:  return 11'($signed($urandom_range(40)) - 20);
      GAINS_TOP:    return GainTop;
      GAINS_BOTTOM: return GainBottom;
      default:      return 11'($urandom);
    endcase
  endfunction

  // A slow drift like a real tilt sensor for 40 in 100 words, with jumps, zeros and raw patterns.
  function automatic logic [pbmd_pkg::TiltW-1:0] pick_tilt();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      tilt_walk = tilt_walk + $signed($urandom_range(10)) - 5;
      if (tilt_walk > 180) tilt_walk = 180;
      if (tilt_walk < -180) tilt_walk = -180;
      return 9'(tilt_walk);
    end
    if (r < 70) return 9'($signed($urandom_range(360)) - 180);
    if (r < 85) return 9'($urandom);
    return '0;
  endfunction

  initial begin
    int reset_gain_tilts[$];
    int top_gain_tilts[$];
    int bottom_gain_tilts[$];
    gain_mix_e phase_mix[PhaseCount];
    reset_gain_tilts  = '{0, 1, -1, 209, 210, 211, 255, -256, -254, 0, 180, -180, 0};
    top_gain_tilts    = '{255, 255, -256, -256, 0, 0};
    bottom_gain_tilts = '{255, -256, 0, 7};
    phase_mix = '{GAINS_SMALL, GAINS_SMALL, GAINS_FULL, GAINS_TOP, GAINS_SMALL,
                  GAINS_FULL, GAINS_BOTTOM, GAINS_SMALL, GAINS_FULL};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gains: stop with no held duty, left-boost cap edge, telemetry floor
    foreach (reset_gain_tilts[k]) send_tilt(9'(reset_gain_tilts[k]));
    drain();
    program_gains(GainTop, GainTop, GainTop);
    foreach (top_gain_tilts[k]) send_tilt(9'(top_gain_tilts[k]));
    drain();
    program_gains(GainBottom, GainBottom, GainBottom);
    foreach (bottom_gain_tilts[k]) send_tilt(9'(bottom_gain_tilts[k]));
    drain();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      program_gains(pick_gain(phase_mix[ph]), pick_gain(phase_mix[ph]),
                    pick_gain(phase_mix[ph]));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      // fill the pipeline against a stalled output while words keep coming
      if (ph == 4) hold_req = 1'b1;
      repeat (PhaseWords) send_tilt(pick_tilt());
      drain();
    end

    repeat (4) @(posedge clk_i);
    $display("Summary: %0d tilt words over %0d gain settings, %0d result words checked;",
             words_sent, gain_sets + 1, results);
    $display("  extreme gains and tilts, idle/stall mixes and one long output hold-off.");
    if (errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
